FILE: hw/rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// shared types, widths and constants of the modular exponentiation unit
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int BASE_WIDTH        = 31;
   localparam int EXP_FIELD_WIDTH   = 31;
   localparam int RESIDUE_WIDTH     = 30;
   localparam int DEFAULT_EXP_WIDTH = 31;

   // bit-serial multiplier scans one operand bit per cycle
   localparam int MUL_BITS      = RESIDUE_WIDTH;
   localparam int MUL_CNT_WIDTH = $clog2(MUL_BITS + 1);

   typedef logic [BASE_WIDTH-1:0]      base_type;
   typedef logic [EXP_FIELD_WIDTH-1:0] exponent_type;
   typedef logic [RESIDUE_WIDTH-1:0]   residue_type;

   localparam residue_type PRIME_MODULUS = 30'd1000000007;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_LOOP,
      ST_WAIT,
      ST_DONE
   } modexp_state_type;

endpackage

FILE: hw/rtl/modexp_if.sv
// ----------------------------------------------------------------------------
// modexp channel interfaces
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface modexp_req_if import modexp_pkg::*; ();
   logic         valid;
   logic         ready;
   base_type     base_value;
   exponent_type exponent_value;

   modport source (output valid, output base_value, output exponent_value, input ready);
   modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface modexp_rsp_if import modexp_pkg::*; ();
   logic        valid;
   logic        ready;
   residue_type power_residue;

   modport source (output valid, output power_residue, input ready);
   modport sink   (input valid, input power_residue, output ready);
endinterface

FILE: hw/rtl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base^exponent mod 1000000007 by right-to-left square and multiply
//
// req_if carries base_value and exponent_value; a transfer happens when
// valid and ready are both high. rsp_if returns one power_residue per
// request. One request is worked on at a time.
// The base is first reduced below the modulus by repeated subtraction, then
// each of the EXP_WIDTH scanned exponent bits takes one pass of the two
// bit-serial multipliers, then the result goes to the output register. The
// two bit-serial multipliers scan 30 operand bits one per cycle and
// form the accumulator product and the square of the base side by side.
// A new request is not taken before the last result has left the datapath.
// The result sits in an output register; a new request is taken while it
// waits. When the receiver stalls, a finished result waits for the register
// to empty. Reset clears all control state and drops the response valid.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit import modexp_pkg::*; #(
   parameter int EXP_WIDTH = DEFAULT_EXP_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   modexp_req_if.sink     req_if,
   modexp_rsp_if.source   rsp_if
);

   localparam int CNT_WIDTH = $clog2(EXP_WIDTH + 1);

   modexp_state_type     state_ff, state_in;
   logic [CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [EXP_WIDTH-1:0] exp_ff, exp_in;
   base_type             red_ff, red_in;
   residue_type          run_ff, run_in;
   residue_type          acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   residue_type          rsp_data_ff, rsp_data_in;

   logic [63:0]          exp_wide;
   logic                 mul_start;
   logic                 acc_done;
   logic                 sq_done;
   residue_type          acc_prod;
   residue_type          sq_prod;

   assign exp_wide = 64'(req_if.exponent_value);

   modexp_mulmod u_acc_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (acc_ff),
      .multiplier   (run_ff),
      .done         (acc_done),
      .product      (acc_prod)
   );

   modexp_mulmod u_sq_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (run_ff),
      .multiplier   (run_ff),
      .done         (sq_done),
      .product      (sq_prod)
   );

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      exp_in       = exp_ff;
      red_in       = red_ff;
      run_in       = run_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;

      // response transfer
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               red_in     = req_if.base_value;
               exp_in     = exp_wide[EXP_WIDTH-1:0];
               bit_cnt_in = CNT_WIDTH'(EXP_WIDTH);
               acc_in     = RESIDUE_WIDTH'(1);
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (red_ff >= BASE_WIDTH'(PRIME_MODULUS)) begin
               red_in = red_ff - BASE_WIDTH'(PRIME_MODULUS);
            end else begin
               run_in   = red_ff[RESIDUE_WIDTH-1:0];
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (bit_cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (acc_done && sq_done) begin
               if (exp_ff[0]) begin
                  acc_in = acc_prod;
               end
               run_in     = sq_prod;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff - CNT_WIDTH'(1);
               state_in   = ST_LOOP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff      <= exp_in;
      red_ff      <= red_in;
      run_ff      <= run_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.power_residue = rsp_data_ff;

endmodule

FILE: hw/rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// bit-serial modular multiplier, multiplier scanned msb first, one bit a cycle
// ----------------------------------------------------------------------------
module modexp_mulmod import modexp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  residue_type multiplicand,
   input  residue_type multiplier,
   output logic        done,
   output residue_type product
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MUL_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   residue_type              a_ff, a_in;
   residue_type              b_ff, b_in;
   residue_type              r_ff, r_in;

   logic [RESIDUE_WIDTH:0]   dbl;
   residue_type              dbl_red;
   logic [RESIDUE_WIDTH:0]   sum;
   residue_type              step;

   // r = 2r + bit*a, each add followed by one conditional subtract
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, PRIME_MODULUS}) ? RESIDUE_WIDTH'(dbl - {1'b0, PRIME_MODULUS})
                                              : dbl[RESIDUE_WIDTH-1:0];
      sum     = {1'b0, dbl_red} + (b_ff[RESIDUE_WIDTH-1] ? {1'b0, a_ff}
                                                          : {(RESIDUE_WIDTH+1){1'b0}});
      step    = (sum >= {1'b0, PRIME_MODULUS}) ? RESIDUE_WIDTH'(sum - {1'b0, PRIME_MODULUS})
                                              : sum[RESIDUE_WIDTH-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MUL_CNT_WIDTH'(MUL_BITS);
         a_in    = multiplicand;
         b_in    = multiplier;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = step;
         b_in   = {b_ff[RESIDUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - MUL_CNT_WIDTH'(1);
         if (cnt_ff == MUL_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule
